[design/eight_bit_cpu_execute_stage_core_defines.svh]
// Assertion macros used by the execute stage top level.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef EIGHT_BIT_CPU_EXECUTE_STAGE_CORE_DEFINES_SVH
`define EIGHT_BIT_CPU_EXECUTE_STAGE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset.
`define ECPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ECPU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ECPU_ASSERT(lbl, prop, msg)
`define ECPU_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[design/ecpu_pkg.sv]
// Shared types and constants of the 8-bit execute stage.
// No dependencies; imported by ecpu_alu and the top level.
`timescale 1ns / 1ps

package ecpu_pkg;

  localparam int REG_COUNT  = 64;    // power of two; the index wraps by truncation
  localparam int DATA_DEPTH = 2048;
  localparam int FIELD_W    = 6;
  localparam int DATA_W     = 8;
  localparam int PC_W       = 16;
  localparam int FLAG_W     = 5;
  localparam int REG_AW     = $clog2(REG_COUNT);
  // Data addresses come from a 6-bit field, so only the low words are reachable.
  localparam int DM_WORDS   = (DATA_DEPTH < (1 << FIELD_W)) ? DATA_DEPTH : (1 << FIELD_W);
  localparam int DM_AW      = $clog2(DM_WORDS);
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  localparam int FLG_C = 0;
  localparam int FLG_V = 1;
  localparam int FLG_N = 2;
  localparam int FLG_S = 3;
  localparam int FLG_Z = 4;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_MOVI = 4'd3,
    OP_BEQZ = 4'd4,
    OP_ANDI = 4'd5,
    OP_EOR  = 4'd6,
    OP_BR   = 4'd7,
    OP_SAL  = 4'd8,
    OP_SAR  = 4'd9,
    OP_LDR  = 4'd10,
    OP_STR  = 4'd11
  } opcode_t;

  typedef struct packed {
    logic              wr;
    logic              mw;
    logic [DATA_W-1:0] val;
    logic [FLAG_W-1:0] flags;
    logic              redir;
    logic [PC_W-1:0]   target;
  } exec_res_t;

endpackage

[design/ecpu_alu.sv]
// Combinational execute unit: operation, flag update and branch target.
// Depends on ecpu_pkg for the opcode type and the result struct.
`timescale 1ns / 1ps

module ecpu_alu (
  input  logic [3:0]                 func,
  input  logic [ecpu_pkg::DATA_W-1:0]  opa,
  input  logic [ecpu_pkg::DATA_W-1:0]  opb,
  input  logic [ecpu_pkg::DATA_W-1:0]  ld_data,
  input  logic [ecpu_pkg::FIELD_W-1:0] field_b,
  input  logic [ecpu_pkg::PC_W-1:0]    pc,
  input  logic [ecpu_pkg::FLAG_W-1:0]  flags_in,
  output ecpu_pkg::exec_res_t          res
);
  import ecpu_pkg::*;

  logic [DATA_W:0]     sum;
  logic [DATA_W-1:0]   diff;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   imm8;
  logic [PC_W-1:0]     off16;
  logic                big_shift;
  logic [DATA_W-1:0]   sal_val;
  logic [DATA_W-1:0]   sar_val;
  logic [DATA_W-1:0]   r;
  logic                nz_upd;
  logic                vs_upd;
  logic                v_bit;

  assign sum   = {1'b0, opa} + {1'b0, opb};
  assign diff  = opa - opb;
  assign prod  = opa * opb;
  assign imm8  = {{(DATA_W-FIELD_W){field_b[FIELD_W-1]}}, field_b};
  assign off16 = {{(PC_W-FIELD_W){field_b[FIELD_W-1]}}, field_b};

  // Shift amounts of eight or more flush the byte; an arithmetic shift by
  // seven already leaves only sign bits.
  assign big_shift = |field_b[FIELD_W-1:3];
  assign sal_val   = big_shift ? '0 : (opa << field_b[2:0]);
  assign sar_val   = DATA_W'($signed(opa) >>> (big_shift ? 3'd7 : field_b[2:0]));

  always_comb begin
    res    = '0;
    res.flags = flags_in;
    r      = '0;
    nz_upd = 1'b0;
    vs_upd = 1'b0;
    v_bit  = 1'b0;
    case (opcode_t'(func))
      OP_ADD: begin
        r      = sum[DATA_W-1:0];
        res.wr = 1'b1;
        nz_upd = 1'b1;
        vs_upd = 1'b1;
        res.flags[FLG_C] = sum[DATA_W];
        v_bit  = ~(opa[DATA_W-1] ^ opb[DATA_W-1]) & (opa[DATA_W-1] ^ r[DATA_W-1]);
      end
      OP_SUB: begin
        r      = diff;
        res.wr = 1'b1;
        nz_upd = 1'b1;
        vs_upd = 1'b1;
        v_bit  = (opa[DATA_W-1] ^ opb[DATA_W-1]) & (opa[DATA_W-1] ^ r[DATA_W-1]);
      end
      OP_MUL: begin
        r      = prod[DATA_W-1:0];
        res.wr = 1'b1;
        nz_upd = 1'b1;
      end
      OP_MOVI: begin
        r      = imm8;
        res.wr = 1'b1;
      end
      OP_BEQZ: begin
        if (opa == '0) begin
          res.redir  = 1'b1;
          res.target = pc + PC_W'(1) + off16;
        end
      end
      OP_ANDI: begin
        r      = opa & imm8;
        res.wr = 1'b1;
        nz_upd = 1'b1;
      end
      OP_EOR: begin
        r      = opa ^ opb;
        res.wr = 1'b1;
        nz_upd = 1'b1;
      end
      OP_BR: begin
        res.redir  = 1'b1;
        res.target = {opa, opb};
      end
      OP_SAL: begin
        r      = sal_val;
        res.wr = 1'b1;
        nz_upd = 1'b1;
      end
      OP_SAR: begin
        r      = sar_val;
        res.wr = 1'b1;
        nz_upd = 1'b1;
      end
      OP_LDR: begin
        r      = ld_data;
        res.wr = 1'b1;
      end
      OP_STR: begin
        r      = opa;
        res.mw = 1'b1;
      end
      default: begin
        r = '0;
      end
    endcase

    if (nz_upd) begin
      res.flags[FLG_N] = r[DATA_W-1];
      res.flags[FLG_Z] = (r == '0);
    end
    // S follows the N value that this same instruction produced.
    if (vs_upd) begin
      res.flags[FLG_V] = v_bit;
      res.flags[FLG_S] = res.flags[FLG_N] ^ v_bit;
    end
    res.val = (res.wr | res.mw) ? r : '0;
  end

endmodule

[design/eight_bit_cpu_execute_stage_core.sv]
// Top level of the 8-bit execute stage: register file and data store
// memories, operand bypass, stream handshake and output register.
// Depends on ecpu_pkg, ecpu_alu and eight_bit_cpu_execute_stage_core_defines.svh.
// Pipeline: an accepted input beat is held in the execute stage registers, then its result in the output register.
// Throughput: one instruction per cycle unless the output stalls; the register file's two read ports
//   and the data store's read port are read as the beat is accepted, and the
//   last write is forwarded so back-to-back dependences cost nothing.
// Reset: synchronous, active low; clears the pipeline valids, the flags and
//   the per-entry valid bits, so registers and data words read zero until written.
`timescale 1ns / 1ps

`include "eight_bit_cpu_execute_stage_core_defines.svh"

module eight_bit_cpu_execute_stage_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // func[3:0], reg_a[9:4], field_b[15:10], instr_addr[31:16]
  input  logic [ecpu_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // reg_written[0], written_value[8:1], mem_written[9], status[14:10],
  // redirect[15], target_pc[31:16]
  output logic [ecpu_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ecpu_pkg::*;

  // Input unpacking.
  logic [3:0]         in_func;
  logic [FIELD_W-1:0] in_ra;
  logic [FIELD_W-1:0] in_fb;
  logic [PC_W-1:0]    in_pc;

  assign in_func = in_tdata[3:0];
  assign in_ra   = in_tdata[9:4];
  assign in_fb   = in_tdata[15:10];
  assign in_pc   = in_tdata[31:16];

  logic in_fire;
  logic commit;

  // Execute stage registers.
  logic               s1_v_r, s1_v_nxt;
  logic [3:0]         s1_func_r;
  logic [FIELD_W-1:0] s1_ra_r;
  logic [FIELD_W-1:0] s1_fb_r;
  logic [PC_W-1:0]    s1_pc_r;

  // Memories and their registered read data.
  logic [DATA_W-1:0] rf_mem [REG_COUNT];
  logic [DATA_W-1:0] dm_mem [DM_WORDS];
  logic [DATA_W-1:0] rf_rd_a_r;
  logic [DATA_W-1:0] rf_rd_b_r;
  logic [DATA_W-1:0] dm_rd_r;
  logic [REG_COUNT-1:0] rf_vld_r;
  logic [DM_WORDS-1:0]  dm_vld_r;

  // Most recent write to each memory.
  logic              byp_rf_v_r;
  logic [REG_AW-1:0] byp_rf_addr_r;
  logic [DATA_W-1:0] byp_rf_data_r;
  logic              byp_dm_v_r;
  logic [DM_AW-1:0]  byp_dm_addr_r;
  logic [DATA_W-1:0] byp_dm_data_r;

  logic [FLAG_W-1:0] status_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [REG_AW-1:0] s1_ia;
  logic [REG_AW-1:0] s1_ib;
  logic [DM_AW-1:0]  s1_ma;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] ld_data;
  exec_res_t         res;

  assign commit    = s1_v_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_v_r | commit;
  assign in_fire   = in_tvalid & in_tready;

  assign s1_v_nxt      = in_fire ? 1'b1 : (commit ? 1'b0 : s1_v_r);
  assign out_valid_nxt = commit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  assign s1_ia = s1_ra_r[REG_AW-1:0];
  assign s1_ib = s1_fb_r[REG_AW-1:0];
  assign s1_ma = s1_fb_r[DM_AW-1:0];

  // The read was issued when the beat was accepted; a write committed on that
  // same edge is not in the read data, so the last write is forwarded.
  always_comb begin
    if (byp_rf_v_r && byp_rf_addr_r == s1_ia) begin
      opa = byp_rf_data_r;
    end else if (rf_vld_r[s1_ia]) begin
      opa = rf_rd_a_r;
    end else begin
      opa = '0;
    end
    if (byp_rf_v_r && byp_rf_addr_r == s1_ib) begin
      opb = byp_rf_data_r;
    end else if (rf_vld_r[s1_ib]) begin
      opb = rf_rd_b_r;
    end else begin
      opb = '0;
    end
    if (byp_dm_v_r && byp_dm_addr_r == s1_ma) begin
      ld_data = byp_dm_data_r;
    end else if (dm_vld_r[s1_ma]) begin
      ld_data = dm_rd_r;
    end else begin
      ld_data = '0;
    end
  end

  ecpu_alu u_alu (
    .func     (s1_func_r),
    .opa      (opa),
    .opb      (opb),
    .ld_data  (ld_data),
    .field_b  (s1_fb_r),
    .pc       (s1_pc_r),
    .flags_in (status_r),
    .res      (res)
  );

  // Memory arrays: reads on accept, writes on commit.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rf_rd_a_r <= rf_mem[in_ra[REG_AW-1:0]];
      rf_rd_b_r <= rf_mem[in_fb[REG_AW-1:0]];
      dm_rd_r   <= dm_mem[in_fb[DM_AW-1:0]];
    end
    if (commit && res.wr) begin
      rf_mem[s1_ia] <= res.val;
    end
    if (commit && res.mw) begin
      dm_mem[s1_ma] <= res.val;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= in_func;
      s1_ra_r   <= in_ra;
      s1_fb_r   <= in_fb;
      s1_pc_r   <= in_pc;
    end
    if (commit) begin
      out_data_r <= {res.target, res.redir, res.flags, res.mw, res.val, res.wr};
    end
    if (commit && res.wr) begin
      byp_rf_addr_r <= s1_ia;
      byp_rf_data_r <= res.val;
    end
    if (commit && res.mw) begin
      byp_dm_addr_r <= s1_ma;
      byp_dm_data_r <= res.val;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= '0;
      rf_vld_r    <= '0;
      dm_vld_r    <= '0;
      byp_rf_v_r  <= 1'b0;
      byp_dm_v_r  <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        status_r <= res.flags;
      end
      if (commit && res.wr) begin
        rf_vld_r[s1_ia] <= 1'b1;
        byp_rf_v_r      <= 1'b1;
      end
      if (commit && res.mw) begin
        dm_vld_r[s1_ma] <= 1'b1;
        byp_dm_v_r      <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ECPU_ASSERT(a_rf_vld_after_wr, commit && res.wr |=> rf_vld_r[$past(s1_ia)], "register write did not mark its entry valid")
  `ECPU_ASSERT(a_flags_hold, !commit |=> $stable(status_r), "flags changed without a committed instruction")
  `ECPU_ASSERT(a_no_redirect_zero_pc, out_valid_r && !out_data_r[15] |-> out_data_r[31:16] == '0, "target_pc nonzero without redirect")
  `ECPU_ASSERT(a_idle_value_zero, out_valid_r && !out_data_r[0] && !out_data_r[9] |-> out_data_r[8:1] == '0, "written_value nonzero with no write")
  `ECPU_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid && !s1_v_r, "pipeline not empty after reset")

endmodule

[bench/eight_bit_cpu_execute_stage_core_test.sv]
// Self-checking bench for the 8-bit execute stage: directed rows, then random instructions.
// Needs ecpu_pkg and the eight_bit_cpu_execute_stage_core RTL. A local executor predicts
// each result beat, with random stalls on both stream sides.
`timescale 1ns / 1ps

module eight_bit_cpu_execute_stage_core_test;
  import ecpu_pkg::*;

  localparam logic [3:0] OP_SPARE_12 = 4'd12;
  localparam logic [3:0] OP_SPARE_15 = 4'd15;
  localparam logic [FLAG_W-1:0] ST_Z = 5'b1 << FLG_Z;
  localparam int RANDOM_INSTRS = 1700;
  localparam int IDLE_PCT = 27;

  // Both structs are laid out so that they map straight onto the tdata buses.
  typedef struct packed {
    logic [PC_W-1:0]    instr_addr;
    logic [FIELD_W-1:0] field_b;
    logic [FIELD_W-1:0] reg_a;
    logic [3:0]         func;
  } instr_beat_t;

  typedef struct packed {
    logic [PC_W-1:0]   target_pc;
    logic              redirect;
    logic [FLAG_W-1:0] status;
    logic              mem_written;
    logic [DATA_W-1:0] written_value;
    logic              reg_written;
  } result_beat_t;

  typedef struct {
    instr_beat_t  ins;
    bit           typed;
    result_beat_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predicted architectural state.
  logic [DATA_W-1:0] gpr [REG_COUNT];
  logic [DATA_W-1:0] dmem [DM_WORDS];
  logic [FLAG_W-1:0] flags;

  result_beat_t pending_results [$];
  dir_row_t     dir_rows [$];
  bit no_idle = 1'b0;
  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_redirects = 0;
  int n_stores = 0;

  eight_bit_cpu_execute_stage_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic void set_nz(input logic [DATA_W-1:0] r);
    flags[FLG_N] = r[DATA_W-1];
    flags[FLG_Z] = (r == '0);
  endfunction

  function automatic void set_vs(input logic v);
    flags[FLG_V] = v;
    flags[FLG_S] = flags[FLG_N] ^ v;
  endfunction

  function automatic result_beat_t execute_instr(input instr_beat_t ins);
    logic [DATA_W-1:0] a, b, imm, r;
    logic signed [DATA_W-1:0] sa;
    logic [DATA_W:0] sum;
    logic wr, mw;
    result_beat_t res;
    a = gpr[ins.reg_a];
    b = gpr[ins.field_b];
    sa = a;
    imm = {{2{ins.field_b[FIELD_W-1]}}, ins.field_b};
    r = '0;
    wr = 1'b0;
    mw = 1'b0;
    res = '0;
    case (ins.func)
      OP_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        r = sum[DATA_W-1:0];
        set_nz(r);
        flags[FLG_C] = sum[DATA_W];
        set_vs(~(a[7] ^ b[7]) & (a[7] ^ r[7]));
        wr = 1'b1;
      end
      OP_SUB: begin
        r = a - b;
        set_nz(r);
        set_vs((a[7] ^ b[7]) & (a[7] ^ r[7]));
        wr = 1'b1;
      end
      OP_MUL: begin
        r = a * b;
        set_nz(r);
        wr = 1'b1;
      end
      OP_MOVI: begin
        r = imm;
        wr = 1'b1;
      end
      OP_BEQZ: begin
        if (a == '0) begin
          res.redirect = 1'b1;
          res.target_pc = ins.instr_addr + 16'd1 + {{(PC_W-DATA_W){imm[7]}}, imm};
        end
      end
      OP_ANDI: begin
        r = a & imm;
        set_nz(r);
        wr = 1'b1;
      end
      OP_EOR: begin
        r = a ^ b;
        set_nz(r);
        wr = 1'b1;
      end
      OP_BR: begin
        res.redirect = 1'b1;
        res.target_pc = {a, b};
      end
      OP_SAL: begin
        // Shifts of eight or more run every bit out, or fill with the sign.
        r = a << ins.field_b;
        set_nz(r);
        wr = 1'b1;
      end
      OP_SAR: begin
        r = sa >>> ins.field_b;
        set_nz(r);
        wr = 1'b1;
      end
      OP_LDR: begin
        r = dmem[ins.field_b];
        wr = 1'b1;
      end
      OP_STR: begin
        r = a;
        dmem[ins.field_b] = a;
        mw = 1'b1;
      end
      default: ;
    endcase
    if (wr) gpr[ins.reg_a] = r;
    res.reg_written = wr;
    res.mem_written = mw;
    res.written_value = (wr || mw) ? r : '0;
    res.status = flags;
    return res;
  endfunction

  function automatic void dir_row(input logic [3:0] f, input logic [5:0] ra, input logic [5:0] fb,
                                  input logic [15:0] addr, input bit typed, input logic wr,
                                  input logic [7:0] val, input logic mw, input logic [4:0] st,
                                  input logic rd, input logic [15:0] tgt);
    dir_row_t row;
    row.ins = '{instr_addr: addr, field_b: fb, reg_a: ra, func: f};
    row.typed = typed;
    row.want = '{target_pc: tgt, redirect: rd, status: st, mem_written: mw,
                 written_value: val, reg_written: wr};
    dir_rows.push_back(row);
  endfunction

  function automatic logic [5:0] pick_index();
    // Favor a few registers so that results feed the following instructions.
    if ($urandom_range(99) < 60) return 6'($urandom_range(7));
    return 6'($urandom_range(63));
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_instr(input instr_beat_t ins, input bit typed, input result_beat_t want);
    result_beat_t pred;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = ins;
    do @(posedge clk); while (!in_tready);
    pred = execute_instr(ins);
    pending_results.push_back(typed ? want : pred);
    n_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) out_tready = no_idle || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    result_beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      n_results++;
      if (got.redirect) n_redirects++;
      if (got.mem_written) n_stores++;
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no instruction outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("reg_written", want.reg_written, got.reg_written);
        check_field("written_value", want.written_value, got.written_value);
        check_field("mem_written", want.mem_written, got.mem_written);
        check_field("status", want.status, got.status);
        check_field("redirect", want.redirect, got.redirect);
        check_field("target_pc", want.target_pc, got.target_pc);
      end
    end
  end

  initial begin
    instr_beat_t ins;
    logic [3:0] f;
    int wait_cycles;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    flags = '0;

    // Rows right after reset, which start with every register and data word at zero.
    dir_row(OP_ADD,  6'd0,  6'd1,  16'h0000, 1, 1, 8'h00, 0, ST_Z, 0, 16'h0000);
    dir_row(OP_MOVI, 6'd1,  6'h1F, 16'h0001, 1, 1, 8'h1F, 0, ST_Z, 0, 16'h0000);
    dir_row(OP_MOVI, 6'd2,  6'h20, 16'h0002, 1, 1, 8'hE0, 0, ST_Z, 0, 16'h0000);
    dir_row(OP_BEQZ, 6'd0,  6'h3F, 16'hFFFF, 1, 0, 8'h00, 0, ST_Z, 1, 16'hFFFF);
    dir_row(OP_BEQZ, 6'd0,  6'h1F, 16'hFFFF, 1, 0, 8'h00, 0, ST_Z, 1, 16'h001F);
    dir_row(OP_LDR,  6'd3,  6'h3F, 16'h0005, 1, 1, 8'h00, 0, ST_Z, 0, 16'h0000);
    dir_row(OP_STR,  6'd2,  6'h3F, 16'h0006, 1, 0, 8'hE0, 1, ST_Z, 0, 16'h0000);
    dir_row(OP_LDR,  6'd63, 6'h3F, 16'h0007, 1, 1, 8'hE0, 0, ST_Z, 0, 16'h0000);
    // The rest are left to the executor.
    dir_row(OP_ADD,  6'd2,  6'd2,  16'h0008, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_MOVI, 6'd7,  6'h1F, 16'h0009, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_SAL,  6'd7,  6'd2,  16'h000A, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_ADD,  6'd7,  6'd1,  16'h000B, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_MOVI, 6'd8,  6'h20, 16'h000C, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_SAL,  6'd8,  6'd2,  16'h000D, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_SUB,  6'd8,  6'd1,  16'h000E, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_MUL,  6'd2,  6'd1,  16'h000F, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_EOR,  6'd2,  6'd1,  16'h0010, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_ANDI, 6'd63, 6'h2A, 16'h0011, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_SAL,  6'd1,  6'd8,  16'h0012, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_SAR,  6'd8,  6'h3F, 16'h0013, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_BR,   6'd7,  6'd8,  16'h0014, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_BEQZ, 6'd7,  6'h20, 16'h0000, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_SPARE_12, 6'd63, 6'h3F, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);
    dir_row(OP_SPARE_15, 6'd63, 6'h3F, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_instr(dir_rows[i].ins, dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < RANDOM_INSTRS; i++) begin
      no_idle = (i >= 700 && i < 1000);
      f = ($urandom_range(99) < 12) ? OP_MOVI : 4'($urandom_range(15));
      ins.func = f;
      ins.reg_a = pick_index();
      if ((f == OP_SAL || f == OP_SAR) && $urandom_range(99) < 70)
        ins.field_b = 6'($urandom_range(9));
      else
        ins.field_b = pick_index();
      case ($urandom_range(9))
        0: ins.instr_addr = 16'h0000;
        1: ins.instr_addr = 16'hFFFF;
        default: ins.instr_addr = 16'($urandom_range(65535));
      endcase
      send_instr(ins, 1'b0, '0);
    end
    in_tvalid = 1'b0;
    no_idle = 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d instructions (%0d directed), checked %0d result beats.",
             n_sent, dir_rows.size(), n_results);
    $display("Results included %0d taken branches and %0d stores.", n_redirects, n_stores);
    if (errors == 0) begin
      $display("eight_bit_cpu_execute_stage_core_test passed");
    end else begin
      $display("eight_bit_cpu_execute_stage_core_test failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("eight_bit_cpu_execute_stage_core_test failed");
    $finish;
  end

endmodule
